// ===== rtl/hi84_pkg.sv =====
// shared types, constants and code functions of the interleaved hamming (8,4) codec
package hi84_pkg;

   localparam int DataWidth = 16;
   localparam int CodeWidth = 32;
   localparam int NibCount  = 4;
   localparam int NibWidth  = 4;
   localparam int NibCode   = 8;

   localparam logic ReqEncode = 1'b0;
   localparam logic ReqDecode = 1'b1;

   // syndrome {s0,s1,s2} that points at a data bit
   localparam logic [2:0] SynD0 = 3'b110;
   localparam logic [2:0] SynD1 = 3'b011;
   localparam logic [2:0] SynD2 = 3'b101;
   localparam logic [2:0] SynD3 = 3'b111;

   typedef struct packed {
      logic [NibCount-1:0]  uncorrectable_mask;
      logic [NibCount-1:0]  corrected_mask;
      logic [DataWidth-1:0] data_out;
      logic [CodeWidth-1:0] code_out;
   } result_type;

   // code bits c0..c7 of a nibble, c0 in bit 7
   function automatic logic [NibCode-1:0] nib_encode(input logic [NibWidth-1:0] nib);
      logic d0, d1, d2, d3, p0, p1, p2, p3;
      d0 = nib[3];
      d1 = nib[2];
      d2 = nib[1];
      d3 = nib[0];
      p0 = d0 ^ d2 ^ d3;
      p1 = d0 ^ d1 ^ d3;
      p2 = d1 ^ d2 ^ d3;
      p3 = d0 ^ d1 ^ d2 ^ d3 ^ p0 ^ p1 ^ p2;
      return {d0, d1, d2, d3, p0, p1, p2, p3};
   endfunction

   // bit position in the interleaved word of code bit j of nibble i
   function automatic logic [4:0] code_pos(input int i, input int j);
      return 5'(CodeWidth - 1 - 8 * (j >> 1) - 4 * (j & 1) - i);
   endfunction

endpackage

// ===== rtl/hi84_core.sv =====
// encode and check/correct logic for one interleaved 16-bit word
module hi84_core (
   input  logic                               req_type,
   input  logic [hi84_pkg::DataWidth-1:0]     data_word,
   input  logic [hi84_pkg::CodeWidth-1:0]     code_word,
   output hi84_pkg::result_type               result
);
   import hi84_pkg::*;

   always_comb begin
      logic [NibCode-1:0]  cb;
      logic [0:NibCode-1]  c;
      logic [2:0]          syn;
      logic                all_par;
      logic [0:NibWidth-1] flip;
      result = '0;
      for (int i = 0; i < NibCount; i++) begin
         cb      = nib_encode(data_word[DataWidth-1-NibWidth*i -: NibWidth]);
         c       = '0;
         for (int j = 0; j < NibCode; j++) begin
            c[j] = code_word[code_pos(i, j)];
         end
         syn     = {c[4] ^ c[0] ^ c[2] ^ c[3],
                    c[5] ^ c[0] ^ c[1] ^ c[3],
                    c[6] ^ c[1] ^ c[2] ^ c[3]};
         all_par = ^c;
         flip    = '0;
         if (all_par) begin
            unique case (syn)
               SynD0:   flip = 4'b1000;
               SynD1:   flip = 4'b0100;
               SynD2:   flip = 4'b0010;
               SynD3:   flip = 4'b0001;
               default: flip = 4'b0000;
            endcase
         end
         if (req_type == ReqEncode) begin
            for (int j = 0; j < NibCode; j++) begin
               result.code_out[code_pos(i, j)] = cb[NibCode-1-j];
            end
         end else begin
            result.data_out[DataWidth-1-NibWidth*i -: NibWidth] = c[0:NibWidth-1] ^ flip;
            result.corrected_mask[i]     = all_par && (flip != '0);
            result.uncorrectable_mask[i] = !all_par && (syn != '0);
         end
      end
   end

endmodule

// ===== rtl/interleaved_hamming84_codec.sv =====
// top level of the interleaved hamming (8,4) secded memory codec
//
//  channel | dir | tdata (low bit up)                              | tuser
//  req_    | in  | data_word[15:0], code_word[47:16]               | req_type
//  rsp_    | out | code_out[31:0], data_out[47:32],                | -
//          |     | corrected_mask[51:48], uncorrectable_mask[55:52]|
//
// one request per cycle unless rsp_ stalls; a result is offered from the result register
// path: request register, codec logic, result register
// reset empties both registers; payloads are not reset
// a stalled result holds while the request register still takes one more request
module interleaved_hamming84_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_word, code_word
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // code_out, data_out, corrected_mask, uncorrectable_mask
);
   import hi84_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_type_ff;
   logic [DataWidth-1:0] s1_data_ff;
   logic [CodeWidth-1:0] s1_code_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff;
   result_type           core_result;
   logic                 s2_ready;
   logic                 s1_move;
   logic                 req_take;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_take   = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && s2_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   hi84_core u_core (
      .req_type  (s1_type_ff),
      .data_word (s1_data_ff),
      .code_word (s1_code_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req_tuser;
         s1_data_ff <= req_tdata[DataWidth-1:0];
         s1_code_ff <= req_tdata[DataWidth+CodeWidth-1:DataWidth];
      end
      if (s1_move) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.corrected_mask & rsp_data_ff.uncorrectable_mask) == '0))
      else $error("corrected and uncorrectable masks overlap");

   a_encode_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.code_out != '0)) |->
         (rsp_data_ff.data_out == '0 && rsp_data_ff.corrected_mask == '0 &&
          rsp_data_ff.uncorrectable_mask == '0))
      else $error("encode result carries decode fields");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> s1_valid_ff)
      else $error("request register dropped a stalled request");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("taken request not held in request register");
`endif

endmodule

// ===== test/interleaved_hamming84_codec_test.sv =====
// self-checking testbench for the interleaved hamming (8,4) codec
`timescale 1ns / 100ps

module interleaved_hamming84_codec_test;
   import hi84_pkg::*;

   localparam int ClockHalf   = 5;
   localparam int ResetCycles = 5;
   localparam int RandomCount = 650;
   localparam int LongHoldAt  = 150;
   localparam int LongHold    = 400;
   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 10;

   typedef struct {
      logic        req_type;
      logic [15:0] data_word;
      logic [31:0] code_word;
   } codec_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // data_word, code_word
   logic        req_tuser = 1'b0; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // code_out, data_out, corrected_mask, uncorrectable_mask

   codec_request_type queued_requests[$];
   codec_request_type active_request;
   result_type        expected_codec_results[$];

   int request_total = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int send_gap      = 0;
   int recv_stall    = 0;
   int quiet_cycles  = 0;
   bit send_idle_on  = 1'b1;
   bit recv_idle_on  = 1'b1;

   interleaved_hamming84_codec dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #ClockHalf clock = ~clock;

   // bit position of code bit j of nibble nib, nibble 0 holds the top data bits
   function automatic int code_bit_pos(input int nib, input int j);
      return 31 - 8 * (j / 2) - 4 * (j % 2) - nib;
   endfunction

   function automatic logic [31:0] interleave_encode(input logic [15:0] word);
      logic [31:0] code;
      logic [3:0]  nib;
      logic [7:0]  cb;
      code = '0;
      for (int i = 0; i < 4; i++) begin
         nib   = word[15 - 4 * i -: 4];
         cb[0] = nib[3];
         cb[1] = nib[2];
         cb[2] = nib[1];
         cb[3] = nib[0];
         cb[4] = cb[0] ^ cb[2] ^ cb[3];
         cb[5] = cb[0] ^ cb[1] ^ cb[3];
         cb[6] = cb[1] ^ cb[2] ^ cb[3];
         cb[7] = ^cb[6:0];
         for (int j = 0; j < 8; j++) code[code_bit_pos(i, j)] = cb[j];
      end
      return code;
   endfunction

   function automatic result_type predict_codec_result(input codec_request_type request);
      result_type  res;
      logic [7:0]  cb;
      logic [2:0]  syn;
      res = '0;
      if (request.req_type == ReqEncode) begin
         res.code_out = interleave_encode(request.data_word);
      end else begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) cb[j] = request.code_word[code_bit_pos(i, j)];
            syn = {cb[4] ^ cb[0] ^ cb[2] ^ cb[3],
                   cb[5] ^ cb[0] ^ cb[1] ^ cb[3],
                   cb[6] ^ cb[1] ^ cb[2] ^ cb[3]};
            if (^cb) begin
               // odd overall parity: single error, fix it if it hit a data bit
               case (syn)
                  SynD0: begin
                     cb[0] = ~cb[0];
                     res.corrected_mask[i] = 1'b1;
                  end
                  SynD1: begin
                     cb[1] = ~cb[1];
                     res.corrected_mask[i] = 1'b1;
                  end
                  SynD2: begin
                     cb[2] = ~cb[2];
                     res.corrected_mask[i] = 1'b1;
                  end
                  SynD3: begin
                     cb[3] = ~cb[3];
                     res.corrected_mask[i] = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (syn != 3'b000) begin
               res.uncorrectable_mask[i] = 1'b1;
            end
            res.data_out[15 - 4 * i -: 4] = {cb[0], cb[1], cb[2], cb[3]};
         end
      end
      return res;
   endfunction

   task automatic add_request(input logic kind, input logic [15:0] data,
                              input logic [31:0] code);
      codec_request_type request;
      request.req_type  = kind;
      request.data_word = data;
      request.code_word = code;
      queued_requests.push_back(request);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // sender
   always @(posedge clock) begin : drive_requests
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_codec_results.push_back(predict_codec_result(active_request));
            requests_sent++;
            offer    = 1'b0;
            send_gap = send_idle_on ? $urandom_range(0, 19) : 0;
            if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (queued_requests.size() > 0) begin
               active_request = queued_requests.pop_front();
               req_tdata <= {active_request.code_word, active_request.data_word};
               req_tuser <= active_request.req_type;
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : check_results
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_codec_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_codec_results.pop_front();
               compare_field("code_out", want.code_out, got.code_out);
               compare_field("data_out", want.data_out, got.data_out);
               compare_field("corrected_mask", want.corrected_mask, got.corrected_mask);
               compare_field("uncorrectable_mask", want.uncorrectable_mask,
                             got.uncorrectable_mask);
            end
            results_seen++;
            // one long hold-off so the request side backs up
            if (results_seen == LongHoldAt) recv_stall = LongHold;
            else recv_stall = recv_idle_on ? $urandom_range(0, 19) : 0;
            if ($urandom_range(0, 39) == 0) recv_idle_on = !recv_idle_on;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("[interleaved_hamming84_codec] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] code;
      logic [15:0] data;
      int          kind;
      int          flips;

      // encodes
      add_request(ReqEncode, 16'h0000, $urandom);
      add_request(ReqEncode, 16'hFFFF, $urandom);
      add_request(ReqEncode, 16'h8000, $urandom);
      add_request(ReqEncode, 16'h0001, $urandom);
      add_request(ReqEncode, 16'h5A3C, $urandom);
      // raw codeword extremes
      add_request(ReqDecode, 16'($urandom), 32'h0000_0000);
      add_request(ReqDecode, 16'($urandom), 32'hFFFF_FFFF);
      add_request(ReqDecode, 16'($urandom), 32'h8000_0000);
      add_request(ReqDecode, 16'($urandom), 32'h0000_0001);
      // clean codewords
      add_request(ReqDecode, 16'($urandom), interleave_encode(16'h1234));
      add_request(ReqDecode, 16'($urandom), interleave_encode(16'hFFFF));
      // single data-bit errors, then single parity-bit errors, in every nibble
      for (int j = 0; j < 8; j++) begin
         code = interleave_encode(16'h9C61);
         for (int i = 0; i < 4; i++) code ^= 32'd1 << code_bit_pos(i, j);
         add_request(ReqDecode, 16'($urandom), code);
      end
      // double errors: data plus parity, two data bits
      code = interleave_encode(16'h3E7B);
      for (int i = 0; i < 4; i++) code ^= (32'd1 << code_bit_pos(i, 0)) |
                                          (32'd1 << code_bit_pos(i, 4));
      add_request(ReqDecode, 16'($urandom), code);
      code = interleave_encode(16'hC0DE);
      for (int i = 0; i < 4; i++) code ^= (32'd1 << code_bit_pos(i, 1)) |
                                          (32'd1 << code_bit_pos(i, 2));
      add_request(ReqDecode, 16'($urandom), code);
      // mixed: clean, data error, parity error, double error
      code = interleave_encode(16'h7A52);
      code ^= 32'd1 << code_bit_pos(1, 3);
      code ^= 32'd1 << code_bit_pos(2, 6);
      code ^= (32'd1 << code_bit_pos(3, 1)) | (32'd1 << code_bit_pos(3, 7));
      add_request(ReqDecode, 16'($urandom), code);
      // whole nibble inverted passes every check
      code = interleave_encode(16'h4B19);
      for (int j = 0; j < 8; j++) code ^= 32'd1 << code_bit_pos(2, j);
      add_request(ReqDecode, 16'($urandom), code);
      // triple data error looks like a parity error
      code = interleave_encode(16'h0F0F);
      for (int j = 0; j < 3; j++) code ^= 32'd1 << code_bit_pos(1, j);
      add_request(ReqDecode, 16'($urandom), code);

      for (int n = 0; n < RandomCount; n++) begin
         kind = $urandom_range(0, 99);
         data = 16'($urandom);
         code = $urandom;
         if (kind < 25) begin
            add_request(ReqEncode, data, code);
         end else if (kind < 75) begin
            code  = interleave_encode(16'($urandom));
            flips = $urandom_range(0, 19);
            flips = (flips < 4) ? 0 : (flips < 12) ? 1 : (flips < 17) ? 2 : 3;
            repeat (flips) code ^= 32'd1 << $urandom_range(0, 31);
            add_request(ReqDecode, data, code);
         end else begin
            add_request(ReqDecode, data, code);
         end
      end
      request_total = queued_requests.size();

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (requests_sent < request_total || expected_codec_results.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("[interleaved_hamming84_codec] OK");
      end else begin
         $display("[interleaved_hamming84_codec] ERROR");
      end
      $finish;
   end

endmodule
